[sv/kld_pkg.sv]
// shared types and constants for the keyboard line discipline
`default_nettype none
package kld_pkg;

    localparam int LINE_SIZE = 32;
    localparam int LEN_W     = $clog2(LINE_SIZE + 1);
    localparam int ADDR_W    = (LINE_SIZE > 1) ? $clog2(LINE_SIZE) : 1;
    localparam int TOK_MAX   = 9;
    localparam int TOK_W     = $clog2(TOK_MAX + 1);

    // result kinds
    localparam logic [2:0] K_ECHO    = 3'd0;
    localparam logic [2:0] K_DELIVER = 3'd1;
    localparam logic [2:0] K_COMMIT  = 3'd2;
    localparam logic [2:0] K_INTR    = 3'd3;
    localparam logic [2:0] K_STOP    = 3'd4;

    // key kinds
    localparam logic [3:0] KK_MODIFIER  = 4'd1;
    localparam logic [3:0] KK_UP        = 4'd2;
    localparam logic [3:0] KK_DOWN      = 4'd3;
    localparam logic [3:0] KK_RIGHT     = 4'd4;
    localparam logic [3:0] KK_LEFT      = 4'd5;
    localparam logic [3:0] KK_HOME      = 4'd6;
    localparam logic [3:0] KK_END       = 4'd7;
    localparam logic [3:0] KK_BACKSPACE = 4'd8;
    localparam logic [3:0] KK_ENTER     = 4'd9;

    // configuration register indexes
    localparam logic CFG_CANONICAL = 1'b0;
    localparam logic CFG_ECHO      = 1'b1;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [1:0] {OP_PUT, OP_BS, OP_ENTER} op_t;
    typedef enum logic [1:0] {SIG_NONE, SIG_INTR, SIG_STOP} sig_t;
    typedef enum logic [1:0] {STY_SELF, STY_ESC, STY_CTRL} style_t;

    typedef struct packed {
        op_t                        op;
        sig_t                       sig;
        style_t                     style;
        logic [TOK_W-1:0]           count;
        logic [TOK_MAX-1:0][7:0]    tokens;
    } plan_t;

endpackage
`default_nettype wire

[sv/kld_decode.sv]
// turns one key event into a plan: a signal request, a token list and the line operation
`default_nettype none
module kld_decode (
    input  wire logic        pressed,
    input  wire logic [7:0]  ascii_code,
    input  wire logic [7:0]  scan_code,
    input  wire logic [3:0]  key_kind,
    input  wire logic        shift_held,
    input  wire logic        left_alt_held,
    input  wire logic        ctrl_held,
    input  wire logic        system_held,
    input  wire logic        canonical,
    output kld_pkg::plan_t   plan
);

    logic [4:0] mod_code;
    logic [3:0] mod_ones;
    logic [7:0] code_hund;
    logic [7:0] code_rem;
    logic [3:0] code_tens;
    logic [7:0] code_ones;
    logic [7:0] upper;
    logic       is_letter;
    logic       is_cursor;

    assign mod_code  = 5'd1 + {1'b0, system_held, ctrl_held, left_alt_held, shift_held};
    assign mod_ones  = (mod_code >= 5'd10) ? 4'(mod_code - 5'd10) : mod_code[3:0];
    assign is_cursor = (key_kind >= kld_pkg::KK_UP) && (key_kind <= kld_pkg::KK_END);
    assign is_letter = ((ascii_code >= 8'h61) && (ascii_code <= 8'h7A))
                    || ((ascii_code >= 8'h41) && (ascii_code <= 8'h5A));
    assign upper     = (ascii_code >= 8'h61) ? ascii_code - 8'd32 : ascii_code;

    // decimal digits of the key number
    always_comb
    begin
        if (scan_code >= 8'd200)
        begin
            code_hund = 8'd2;
            code_rem  = scan_code - 8'd200;
        end
        else if (scan_code >= 8'd100)
        begin
            code_hund = 8'd1;
            code_rem  = scan_code - 8'd100;
        end
        else
        begin
            code_hund = 8'd0;
            code_rem  = scan_code;
        end
        code_tens = 4'd0;
        for (int i = 1; i < 10; i++)
        begin
            if (code_rem >= 8'(10 * i))
                code_tens = 4'(i);
        end
        code_ones = code_rem - (8'(code_tens) * 8'd10);
    end

    always_comb
    begin
        logic [kld_pkg::TOK_W-1:0] n;
        n = '0;
        plan        = '0;
        plan.op     = kld_pkg::OP_PUT;
        plan.sig    = kld_pkg::SIG_NONE;
        plan.style  = kld_pkg::STY_SELF;
        if (pressed)
        begin
            if (ascii_code == 8'd0)
            begin
                if (key_kind != kld_pkg::KK_MODIFIER)
                begin
                    plan.style = kld_pkg::STY_ESC;
                    plan.tokens[n] = kld_pkg::CH_ESC;
                    n = n + 1'b1;
                    plan.tokens[n] = kld_pkg::CH_LBRK;
                    n = n + 1'b1;
                    if (is_cursor)
                    begin
                        if (mod_code != 5'd1)
                        begin
                            if (mod_code >= 5'd10)
                            begin
                                plan.tokens[n] = kld_pkg::CH_ZERO + 8'd1;
                                n = n + 1'b1;
                            end
                            plan.tokens[n] = kld_pkg::CH_ZERO + 8'(mod_ones);
                            n = n + 1'b1;
                        end
                        case (key_kind)
                            kld_pkg::KK_UP:    plan.tokens[n] = 8'h41;
                            kld_pkg::KK_DOWN:  plan.tokens[n] = 8'h42;
                            kld_pkg::KK_RIGHT: plan.tokens[n] = 8'h43;
                            kld_pkg::KK_LEFT:  plan.tokens[n] = 8'h44;
                            kld_pkg::KK_HOME:  plan.tokens[n] = 8'h48;
                            default:           plan.tokens[n] = 8'h46;
                        endcase
                        n = n + 1'b1;
                    end
                    else
                    begin
                        if (scan_code >= 8'd100)
                        begin
                            plan.tokens[n] = kld_pkg::CH_ZERO + code_hund;
                            n = n + 1'b1;
                        end
                        // a zero tens digit after the hundreds is not printed
                        if (code_rem >= 8'd10)
                        begin
                            plan.tokens[n] = kld_pkg::CH_ZERO + 8'(code_tens);
                            n = n + 1'b1;
                        end
                        plan.tokens[n] = kld_pkg::CH_ZERO + code_ones;
                        n = n + 1'b1;
                        if (mod_code != 5'd1)
                        begin
                            plan.tokens[n] = kld_pkg::CH_SEMI;
                            n = n + 1'b1;
                            if (mod_code >= 5'd10)
                            begin
                                plan.tokens[n] = kld_pkg::CH_ZERO + 8'd1;
                                n = n + 1'b1;
                            end
                            plan.tokens[n] = kld_pkg::CH_ZERO + 8'(mod_ones);
                            n = n + 1'b1;
                        end
                        plan.tokens[n] = kld_pkg::CH_TILDE;
                        n = n + 1'b1;
                    end
                end
            end
            else if (ctrl_held)
            begin
                plan.style = kld_pkg::STY_CTRL;
                if (ascii_code == 8'h63)
                    plan.sig = kld_pkg::SIG_INTR;
                else if (ascii_code == 8'h7A)
                    plan.sig = kld_pkg::SIG_STOP;
                if (is_letter)
                begin
                    plan.tokens[0] = upper - 8'd64;
                    n = kld_pkg::TOK_W'(1);
                end
            end
            else if ((key_kind == kld_pkg::KK_BACKSPACE) && canonical)
            begin
                plan.op = kld_pkg::OP_BS;
            end
            else if ((key_kind == kld_pkg::KK_ENTER) && canonical)
            begin
                plan.op = kld_pkg::OP_ENTER;
                plan.tokens[0] = kld_pkg::CH_NL;
                n = kld_pkg::TOK_W'(1);
            end
            else
            begin
                plan.tokens[0] = ascii_code;
                n = kld_pkg::TOK_W'(1);
            end
        end
        plan.count = n;
    end

endmodule
`default_nettype wire

[sv/kld_line_store.sv]
// generic RAM: one write port, one read port with registered read data
`default_nettype none
module kld_line_store #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                           clk,
    input  wire logic                                           we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]                               wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic      [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        // a write to the address being read is passed through
        if (we && (waddr == raddr))
            rdata_reg <= wdata;
        else
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[sv/keyboard_line_discipline.sv]
// Keyboard line discipline top level: key events in, echo/deliver/commit/signal results out
//
// Key events enter on in_valid/in_stall; a transfer happens when in_valid is high and
// in_stall is low. in_stall is high from the accepting edge until every result of that
// event has left the result staging register, so one event is worked on at a time.
// Results leave on out_valid/out_stall, one per transfer, with last on the final one;
// a release, a lone modifier or a dropped byte may give no result at all.
// A single put unit handles one byte at a time: each generated byte is echoed when echo is
// on (a ctrl letter as a caret and the letter) and then stored or delivered, at most 9
// bytes for an escape sequence. A signal adds one result ahead of the bytes, and enter
// then drains every stored byte (up to 32) as deliver results and ends with a commit.
// Each result waits in a staging register until the next one or the end of the event
// shows whether last is set, then moves to the output. When the receiver stalls, the
// sequencer holds as soon as both registers are full.
// cfg_write writes canonical_mode (index 0) or echo_enable (index 1) at the edge;
// writes belong between events.
// Reset clears the line length, sets canonical mode and echo, and drops any work
// in progress; the line store contents are not cleared.
`default_nettype none
module keyboard_line_discipline (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        pressed,
    input  wire logic [7:0]  ascii_code,
    input  wire logic [7:0]  scan_code,
    input  wire logic [3:0]  key_kind,
    input  wire logic        shift_held,
    input  wire logic        left_alt_held,
    input  wire logic        ctrl_held,
    input  wire logic        system_held,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [2:0]  out_kind,
    output logic      [7:0]  out_byte,
    output logic             last
);

    typedef enum logic [3:0] {
        S_IDLE, S_SIG, S_ECHO_A, S_ECHO_B, S_FINAL, S_BS, S_DRAIN, S_COMMIT, S_FINISH
    } state_t;

    state_t                            state_reg, state_next;
    kld_pkg::plan_t                    plan_reg, plan_next;
    kld_pkg::plan_t                    plan_in;
    logic                              canon_reg, canon_next;
    logic                              echo_en_reg, echo_en_next;
    logic [kld_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [kld_pkg::TOK_W-1:0]         tok_idx_reg, tok_idx_next;
    logic [kld_pkg::LEN_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic [2:0]                        pend_kind_reg, pend_kind_next;
    logic [7:0]                        pend_byte_reg, pend_byte_next;
    logic                              out_valid_reg, out_valid_next;
    logic [2:0]                        out_kind_reg, out_kind_next;
    logic [7:0]                        out_byte_reg, out_byte_next;
    logic                              last_reg, last_next;

    logic                              out_free;
    logic                              step_en;
    logic                              gen_valid;
    logic [2:0]                        gen_kind;
    logic [7:0]                        gen_byte;
    logic [7:0]                        tok_byte;
    logic                              tok_last;
    logic                              fits;
    logic                              st_we;
    logic [7:0]                        st_rdata;

    kld_decode u_decode (
        .pressed       (pressed),
        .ascii_code    (ascii_code),
        .scan_code     (scan_code),
        .key_kind      (key_kind),
        .shift_held    (shift_held),
        .left_alt_held (left_alt_held),
        .ctrl_held     (ctrl_held),
        .system_held   (system_held),
        .canonical     (canon_reg),
        .plan          (plan_in)
    );

    // read address runs one step ahead so st_rdata matches rd_idx_reg
    kld_line_store #(
        .WIDTH (8),
        .DEPTH (kld_pkg::LINE_SIZE)
    ) u_line_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (len_reg[kld_pkg::ADDR_W-1:0]),
        .wdata (tok_byte),
        .raddr (rd_idx_next[kld_pkg::ADDR_W-1:0]),
        .rdata (st_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign step_en  = !pend_valid_reg || out_free;
    assign tok_byte = plan_reg.tokens[tok_idx_reg];
    assign tok_last = (tok_idx_reg + 1'b1) == plan_reg.count;
    assign fits     = !canon_reg || (len_reg < kld_pkg::LEN_W'(kld_pkg::LINE_SIZE));

    always_comb
    begin
        state_t after_tok;
        after_tok = (plan_reg.op == kld_pkg::OP_ENTER) ? S_DRAIN : S_FINISH;

        state_next      = state_reg;
        plan_next       = plan_reg;
        canon_next      = canon_reg;
        echo_en_next    = echo_en_reg;
        len_next        = len_reg;
        tok_idx_next    = tok_idx_reg;
        rd_idx_next     = rd_idx_reg;
        gen_valid       = 1'b0;
        gen_kind        = kld_pkg::K_ECHO;
        gen_byte        = 8'd0;
        st_we           = 1'b0;

        if (cfg_write)
        begin
            if (cfg_index == kld_pkg::CFG_CANONICAL)
                canon_next = cfg_data;
            else
                echo_en_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    plan_next    = plan_in;
                    tok_idx_next = '0;
                    if (plan_in.sig != kld_pkg::SIG_NONE)
                        state_next = S_SIG;
                    else if (plan_in.op == kld_pkg::OP_BS)
                        state_next = S_BS;
                    else if (plan_in.count != '0)
                        state_next = S_ECHO_A;
                    else
                        state_next = S_FINISH;
                end
            end
            S_SIG:
            begin
                if (step_en)
                begin
                    gen_valid  = 1'b1;
                    gen_kind   = (plan_reg.sig == kld_pkg::SIG_INTR) ? kld_pkg::K_INTR
                                                                    : kld_pkg::K_STOP;
                    state_next = (plan_reg.count != '0) ? S_ECHO_A : S_FINISH;
                end
            end
            S_ECHO_A:
            begin
                if (step_en)
                begin
                    if (!fits)
                    begin
                        // line full: byte dropped without echo
                        if (tok_last)
                        begin
                            state_next  = after_tok;
                            rd_idx_next = '0;
                        end
                        else
                        begin
                            tok_idx_next = tok_idx_reg + 1'b1;
                        end
                    end
                    else if (echo_en_reg)
                    begin
                        gen_valid = 1'b1;
                        if ((plan_reg.style == kld_pkg::STY_CTRL)
                            || ((plan_reg.style == kld_pkg::STY_ESC) && (tok_idx_reg == '0)))
                            gen_byte = kld_pkg::CH_CARET;
                        else
                            gen_byte = tok_byte;
                        state_next = (plan_reg.style == kld_pkg::STY_CTRL) ? S_ECHO_B : S_FINAL;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_ECHO_B:
            begin
                if (step_en)
                begin
                    gen_valid  = 1'b1;
                    gen_byte   = tok_byte + 8'd64;
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (step_en)
                begin
                    if (canon_reg)
                    begin
                        st_we    = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                    else
                    begin
                        gen_valid = 1'b1;
                        gen_kind  = kld_pkg::K_DELIVER;
                        gen_byte  = tok_byte;
                    end
                    if (tok_last)
                    begin
                        state_next  = after_tok;
                        rd_idx_next = '0;
                    end
                    else
                    begin
                        tok_idx_next = tok_idx_reg + 1'b1;
                        state_next   = S_ECHO_A;
                    end
                end
            end
            S_BS:
            begin
                if (step_en)
                begin
                    if (len_reg != '0)
                    begin
                        len_next  = len_reg - 1'b1;
                        gen_valid = 1'b1;
                        gen_byte  = kld_pkg::CH_BS;
                    end
                    state_next = S_FINISH;
                end
            end
            S_DRAIN:
            begin
                if (step_en)
                begin
                    if (rd_idx_reg < len_reg)
                    begin
                        gen_valid   = 1'b1;
                        gen_kind    = kld_pkg::K_DELIVER;
                        gen_byte    = st_rdata;
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                    else
                    begin
                        len_next   = '0;
                        state_next = S_COMMIT;
                    end
                end
            end
            S_COMMIT:
            begin
                if (step_en)
                begin
                    gen_valid  = 1'b1;
                    gen_kind   = kld_pkg::K_COMMIT;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result staging: each result waits in pend until the next one or the end of the event shows whether it was last
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_free ? 1'b0 : out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        last_next       = last_reg;

        if (gen_valid)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = pend_kind_reg;
                out_byte_next  = pend_byte_reg;
                last_next      = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_kind_next  = gen_kind;
            pend_byte_next  = gen_byte;
        end
        else if ((state_reg == S_FINISH) && pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = pend_kind_reg;
            out_byte_next   = pend_byte_reg;
            last_next       = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            plan_reg       <= '0;
            canon_reg      <= 1'b1;
            echo_en_reg    <= 1'b1;
            len_reg        <= '0;
            tok_idx_reg    <= '0;
            rd_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_kind_reg  <= kld_pkg::K_ECHO;
            pend_byte_reg  <= 8'd0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= kld_pkg::K_ECHO;
            out_byte_reg   <= 8'd0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            plan_reg       <= plan_next;
            canon_reg      <= canon_next;
            echo_en_reg    <= echo_en_next;
            len_reg        <= len_next;
            tok_idx_reg    <= tok_idx_next;
            rd_idx_reg     <= rd_idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_kind_reg  <= pend_kind_next;
            pend_byte_reg  <= pend_byte_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_byte_reg   <= out_byte_next;
            last_reg       <= last_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !pend_valid_reg)
        else $error("event accepted while a result is still staged");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= kld_pkg::LEN_W'(kld_pkg::LINE_SIZE))
        else $error("line length beyond line size");

    a_drain_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> (plan_reg.op == kld_pkg::OP_ENTER))
        else $error("line drained for an event other than enter");
`endif

endmodule
`default_nettype wire
